@@ rtl/ata_pkg.sv @@
package ata_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  // vector guard bits and headroom for the cordic gain
  localparam int GUARD_BITS = 8;
  localparam int VEC_HEAD   = 3;

  // angle accumulator: degrees with 16 fraction bits, result with 8
  localparam int ACC_W     = 25;
  localparam int ACC_FRAC  = 16;
  localparam int OUT_FRAC  = 8;
  localparam int OUT_W     = 17;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ACC_W-1:0] DEG90_ACC  = ACC_W'(90 * (1 << ACC_FRAC));
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (ACC_FRAC - OUT_FRAC - 1));

  localparam logic [OUT_W-1:0] DEG90_OUT  = OUT_W'(90 * (1 << OUT_FRAC));
  localparam logic [OUT_W-1:0] DEG180_OUT = OUT_W'(180 * (1 << OUT_FRAC));
  localparam logic [OUT_W-1:0] DEG270_OUT = OUT_W'(270 * (1 << OUT_FRAC));
  localparam logic [OUT_W-1:0] DEG360_OUT = OUT_W'(360 * (1 << OUT_FRAC));

  typedef struct packed {
    logic den_zero;
    logic den_neg;
    logic num_zero;
    logic num_neg;
  } quad_t;

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic logic signed [ACC_W-1:0] atan_step(input int idx);
    logic signed [ACC_W-1:0] s;
    case (idx)
      0:       s = ACC_W'(2949120);
      1:       s = ACC_W'(1740967);
      2:       s = ACC_W'(919879);
      3:       s = ACC_W'(466945);
      4:       s = ACC_W'(234379);
      5:       s = ACC_W'(117304);
      6:       s = ACC_W'(58666);
      7:       s = ACC_W'(29335);
      8:       s = ACC_W'(14668);
      9:       s = ACC_W'(7334);
      10:      s = ACC_W'(3667);
      11:      s = ACC_W'(1833);
      12:      s = ACC_W'(917);
      13:      s = ACC_W'(458);
      14:      s = ACC_W'(229);
      15:      s = ACC_W'(115);
      16:      s = ACC_W'(57);
      17:      s = ACC_W'(29);
      18:      s = ACC_W'(14);
      19:      s = ACC_W'(7);
      20:      s = ACC_W'(4);
      21:      s = ACC_W'(2);
      22:      s = ACC_W'(1);
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/ata_prep.sv @@
module ata_prep #(
  parameter int SAMPLE_BITS = 16,
  parameter int VW          = 27
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic        [SAMPLE_BITS-1:0] accel_x_i,
  input  logic        [SAMPLE_BITS-1:0] accel_y_i,
  input  logic        [SAMPLE_BITS-1:0] accel_z_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [VW-1:0]          vx_o [2],
  output logic signed [VW-1:0]          vy_o [2],
  output ata_pkg::quad_t                quad_o [2]
);
  import ata_pkg::*;

  logic                 valid_q;
  logic signed [VW-1:0] den   [2];
  logic signed [VW-1:0] num   [2];
  logic signed [VW-1:0] vx_d  [2];
  logic signed [VW-1:0] vy_d  [2];
  quad_t                quad_d[2];
  logic signed [VW-1:0] vx_q  [2];
  logic signed [VW-1:0] vy_q  [2];
  quad_t                quad_q[2];

  // lane 0 gives atan2(z, y), lane 1 atan2(z, x)
  assign den[0] = {{(VW-SAMPLE_BITS){accel_y_i[SAMPLE_BITS-1]}}, accel_y_i};
  assign den[1] = {{(VW-SAMPLE_BITS){accel_x_i[SAMPLE_BITS-1]}}, accel_x_i};
  assign num[0] = {{(VW-SAMPLE_BITS){accel_z_i[SAMPLE_BITS-1]}}, accel_z_i};
  assign num[1] = num[0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quad_d[l].den_zero = (den[l] == '0);
      quad_d[l].den_neg  = den[l][VW-1];
      quad_d[l].num_zero = (num[l] == '0);
      quad_d[l].num_neg  = num[l][VW-1];
      vx_d[l] = (den[l][VW-1] ? -den[l] : den[l]) <<< GUARD_BITS;
      vy_d[l] = (num[l][VW-1] ? -num[l] : num[l]) <<< GUARD_BITS;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      quad_q <= quad_d;
    end
  end

  assign valid_o = valid_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign quad_o  = quad_q;

endmodule

@@ rtl/ata_cell.sv @@
module ata_cell #(
  parameter int VW    = 27,
  parameter int STAGE = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [VW-1:0]              vx_i   [2],
  input  logic signed [VW-1:0]              vy_i   [2],
  input  logic signed [ata_pkg::ACC_W-1:0]  acc_i  [2],
  input  ata_pkg::quad_t                    quad_i [2],
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [VW-1:0]              vx_o   [2],
  output logic signed [VW-1:0]              vy_o   [2],
  output logic signed [ata_pkg::ACC_W-1:0]  acc_o  [2],
  output ata_pkg::quad_t                    quad_o [2]
);
  import ata_pkg::*;

  localparam logic signed [ACC_W-1:0] STEP = atan_step(STAGE);

  logic                    valid_q;
  logic signed [VW-1:0]    dx    [2];
  logic signed [VW-1:0]    dy    [2];
  logic signed [VW-1:0]    vx_d  [2];
  logic signed [VW-1:0]    vy_d  [2];
  logic signed [ACC_W-1:0] acc_d [2];
  logic signed [VW-1:0]    vx_q  [2];
  logic signed [VW-1:0]    vy_q  [2];
  logic signed [ACC_W-1:0] acc_q [2];
  quad_t                   quad_q[2];

  // rotate towards the x axis; a zero y component leaves the lane alone
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l] = vy_i[l] >>> STAGE;
      dy[l] = vx_i[l] >>> STAGE;
      vx_d[l]  = vx_i[l];
      vy_d[l]  = vy_i[l];
      acc_d[l] = acc_i[l];
      if (vy_i[l][VW-1]) begin
        vx_d[l]  = vx_i[l] - dx[l];
        vy_d[l]  = vy_i[l] + dy[l];
        acc_d[l] = acc_i[l] - STEP;
      end else if (vy_i[l] != '0) begin
        vx_d[l]  = vx_i[l] + dx[l];
        vy_d[l]  = vy_i[l] - dy[l];
        acc_d[l] = acc_i[l] + STEP;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      acc_q  <= acc_d;
      quad_q <= quad_i;
    end
  end

  assign valid_o = valid_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign acc_o   = acc_q;
  assign quad_o  = quad_q;

endmodule

@@ rtl/ata_post.sv @@
module ata_post (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [ata_pkg::ACC_W-1:0]  acc_i  [2],
  input  ata_pkg::quad_t                    quad_i [2],
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic        [ata_pkg::OUT_W-1:0]  tilt_x_o,
  output logic        [ata_pkg::OUT_W-1:0]  tilt_y_o
);
  import ata_pkg::*;

  localparam int SHIFT = ACC_FRAC - OUT_FRAC;

  logic                    valid_q;
  logic signed [ACC_W-1:0] clamped[2];
  logic signed [ACC_W-1:0] rounded[2];
  logic        [OUT_W-1:0] ang    [2];
  logic        [OUT_W-1:0] full   [2];
  logic        [OUT_W-1:0] res_d  [2];
  logic        [OUT_W-1:0] tilt_x_q;
  logic        [OUT_W-1:0] tilt_y_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (acc_i[l][ACC_W-1]) begin
        clamped[l] = '0;
      end else if (acc_i[l] > DEG90_ACC) begin
        clamped[l] = DEG90_ACC;
      end else begin
        clamped[l] = acc_i[l];
      end
      rounded[l] = clamped[l] + ROUND_HALF;
      ang[l]     = OUT_W'(rounded[l][ACC_W-1:SHIFT]);

      // quadrant placement and the exact axis cases
      if (quad_i[l].den_zero) begin
        if (quad_i[l].num_zero) begin
          full[l] = '0;
        end else begin
          full[l] = quad_i[l].num_neg ? DEG270_OUT : DEG90_OUT;
        end
      end else if (quad_i[l].num_zero) begin
        full[l] = quad_i[l].den_neg ? DEG180_OUT : '0;
      end else if (!quad_i[l].den_neg) begin
        full[l] = quad_i[l].num_neg ? DEG360_OUT - ang[l] : ang[l];
      end else begin
        full[l] = quad_i[l].num_neg ? DEG180_OUT + ang[l] : DEG180_OUT - ang[l];
      end

      res_d[l] = (full[l] >= DEG360_OUT) ? full[l] - DEG360_OUT : full[l];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tilt_x_q <= res_d[0];
      tilt_y_q <= res_d[1];
    end
  end

  assign valid_o  = valid_q;
  assign tilt_x_o = tilt_x_q;
  assign tilt_y_o = tilt_y_q;

endmodule

@@ rtl/accel_tilt_angle.sv @@
// a sample passes the ata_prep register, the register of each cordic cell and the ata_post register
// throughput: one sample per cycle while the output is not stalled; each cordic cell of the chain holds one sample
// a stage whose successor is full and stalled holds its sample, empty stages still fill
// reset clears the valid flag of every stage; the data registers are not reset
module accel_tilt_angle #(
  parameter int SAMPLE_BITS  = ata_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_STAGES = ata_pkg::ANGLE_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accel_valid_i,
  output logic                         accel_ready_o,
  input  logic [SAMPLE_BITS-1:0]       accel_x_i,
  input  logic [SAMPLE_BITS-1:0]       accel_y_i,
  input  logic [SAMPLE_BITS-1:0]       accel_z_i,
  output logic                         tilt_valid_o,
  input  logic                         tilt_ready_i,
  output logic [ata_pkg::OUT_W-1:0]    tilt_x_o,
  output logic [ata_pkg::OUT_W-1:0]    tilt_y_o
);
  import ata_pkg::*;

  localparam int VW = SAMPLE_BITS + GUARD_BITS + VEC_HEAD;

  logic                    s_valid[ANGLE_STAGES+1];
  logic                    s_ready[ANGLE_STAGES+1];
  logic signed [VW-1:0]    s_vx   [ANGLE_STAGES+1][2];
  logic signed [VW-1:0]    s_vy   [ANGLE_STAGES+1][2];
  logic signed [ACC_W-1:0] s_acc  [ANGLE_STAGES+1][2];
  quad_t                   s_quad [ANGLE_STAGES+1][2];

  ata_prep #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .VW         (VW)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accel_valid_i),
    .ready_o  (accel_ready_o),
    .accel_x_i(accel_x_i),
    .accel_y_i(accel_y_i),
    .accel_z_i(accel_z_i),
    .valid_o  (s_valid[0]),
    .ready_i  (s_ready[0]),
    .vx_o     (s_vx[0]),
    .vy_o     (s_vy[0]),
    .quad_o   (s_quad[0])
  );

  assign s_acc[0][0] = '0;
  assign s_acc[0][1] = '0;

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
    ata_cell #(
      .VW   (VW),
      .STAGE(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(s_valid[k]),
      .ready_o(s_ready[k]),
      .vx_i   (s_vx[k]),
      .vy_i   (s_vy[k]),
      .acc_i  (s_acc[k]),
      .quad_i (s_quad[k]),
      .valid_o(s_valid[k+1]),
      .ready_i(s_ready[k+1]),
      .vx_o   (s_vx[k+1]),
      .vy_o   (s_vy[k+1]),
      .acc_o  (s_acc[k+1]),
      .quad_o (s_quad[k+1])
    );
  end

  ata_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid[ANGLE_STAGES]),
    .ready_o (s_ready[ANGLE_STAGES]),
    .acc_i   (s_acc[ANGLE_STAGES]),
    .quad_i  (s_quad[ANGLE_STAGES]),
    .valid_o (tilt_valid_o),
    .ready_i (tilt_ready_i),
    .tilt_x_o(tilt_x_o),
    .tilt_y_o(tilt_y_o)
  );

  // final vectors only steer the angle, they are not needed past the last cell
  logic unused_vec;
  always_comb begin
    unused_vec = 1'b0;
    for (int l = 0; l < 2; l++) begin
      unused_vec = unused_vec ^ (^s_vx[ANGLE_STAGES][l]) ^ (^s_vy[ANGLE_STAGES][l]);
    end
  end

endmodule

@@ rtl/ata_checker.sv @@
module ata_checker #(
  parameter int SAMPLE_BITS = ata_pkg::SAMPLE_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         accel_valid_i,
  input logic                         accel_ready_o,
  input logic [SAMPLE_BITS-1:0]       accel_x_i,
  input logic [SAMPLE_BITS-1:0]       accel_y_i,
  input logic [SAMPLE_BITS-1:0]       accel_z_i,
  input logic                         tilt_valid_o,
  input logic                         tilt_ready_i,
  input logic [ata_pkg::OUT_W-1:0]    tilt_x_o,
  input logic [ata_pkg::OUT_W-1:0]    tilt_y_o
);
  import ata_pkg::*;

  // a waiting request keeps its sample
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accel_valid_i && !accel_ready_o |=> accel_valid_i && $stable(accel_x_i)
      && $stable(accel_y_i) && $stable(accel_z_i))
    else $error("waiting request changed");

  // a stalled result holds its angles
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tilt_valid_o && !tilt_ready_i |=> tilt_valid_o && $stable(tilt_x_o) && $stable(tilt_y_o))
    else $error("stalled result changed");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tilt_valid_o |-> tilt_x_o < DEG360_OUT)
    else $error("tilt_x out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tilt_valid_o |-> tilt_y_o < DEG360_OUT)
    else $error("tilt_y out of range");

  // an empty output stage lets the whole chain move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tilt_valid_o |-> accel_ready_o)
    else $error("input stalled with empty output");

endmodule

bind accel_tilt_angle ata_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ata_checker (.*);
